FILE: rtl/core/iba_pkg.sv
`default_nettype none
package iba_pkg;
  localparam int NameW = 64;
  localparam int CountW = 4;
  localparam int IndexW = 3;
  localparam int StatusW = 3;
  localparam int SlotW = 4;
  localparam int AddrW = 7;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_EXISTS    = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_INODE  = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_BLOCKS = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [StatusW-1:0] ST_BAD_INDEX = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NameW-1:0]  name_key;
    logic [CountW-1:0] block_count;
    logic [IndexW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   inode_slot;
    logic [AddrW-1:0]   block_address;
  } rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/iba_if.sv
`default_nettype none
interface iba_req_if import iba_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iba_rsp_if import iba_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iba_bitmap.sv
`default_nettype none
// Free-block map: one bit per block, read one word-bit a cycle for the scan
module iba_bitmap import iba_pkg::*; #(
  parameter int BLOCK_COUNT = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [$clog2(BLOCK_COUNT)-1:0] rd_addr,
  output logic                                rd_taken,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(BLOCK_COUNT)-1:0] wr_addr,
  input  wire logic                           wr_taken
);
  logic [BLOCK_COUNT-1:0] taken;

  // Hold one bit per block, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (wr_en) begin
      taken[wr_addr] <= wr_taken;
    end
  end

  // Register the read bit
  always_ff @(posedge clk) begin
    rd_taken <= taken[rd_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/inode_block_allocator_unit.sv
`default_nettype none
// Inode table with free-block map.
// Channels: req (sink) carries one command: operation, name_key,
// block_count, block_index. rsp (source) returns status, inode_slot and
// block_address, exactly one result per command, in order.
// One command is in work at a time; req is ready only while idle.
// Work per command: the name search reads and then compares each inode in
// turn, and look-ups and commands rejected at dispatch answer after it;
// delete then releases every pointer slot of the file and clears its entry;
// create reads and checks bitmap bits one at a time (up to BLOCK_COUNT) and
// then marks each found block taken. Operation 3 goes straight to the result.
// The next command can be taken in the cycle after its result is accepted.
// The inode table is a synchronous memory with a registered read port;
// used flags and the block map are flip-flops cleared at once by reset,
// so the block is ready in the cycle after reset drops.
// The result waits in an output register until taken; a stalled receiver
// holds the block, and no new command is taken until the result leaves.
module inode_block_allocator_unit import iba_pkg::*; #(
  parameter int INODE_COUNT = 16,
  parameter int BLOCK_COUNT = 128,
  parameter int POINTERS_PER_FILE = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  iba_req_if.sink   req,
  iba_rsp_if.source rsp
);
  localparam int IW = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
  localparam int BW = $clog2(BLOCK_COUNT);
  localparam int PW = (POINTERS_PER_FILE > 1) ? $clog2(POINTERS_PER_FILE) : 1;
  localparam int PCW = $clog2(POINTERS_PER_FILE + 1);
  localparam int MemW = NameW + CountW + POINTERS_PER_FILE * BW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCHK   = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCHECK = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_FREE   = 4'd8;
  localparam logic [3:0] S_CLEAR  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state;
  req_t       cmd;
  logic [MemW-1:0] mem [INODE_COUNT];
  logic [MemW-1:0] rd_data;
  logic [MemW-1:0] ent;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [MemW-1:0] mem_wdata;
  logic [INODE_COUNT-1:0] used;
  logic [IW:0]     idx;
  logic            hit;
  logic [IW-1:0]   hit_slot;
  logic            has_free;
  logic [IW-1:0]   free_slot;
  logic [BW:0]     bptr;
  logic [PCW-1:0]  got;
  logic [POINTERS_PER_FILE*BW-1:0] found;
  logic [PW:0]     pj;
  logic            bm_taken;
  logic            bm_we;
  logic [BW-1:0]   bm_waddr;
  logic            bm_wval;
  rsp_t            result;
  logic            out_valid;

  // Unpack the registered entry
  logic [NameW-1:0]  ent_name;
  logic [CountW-1:0] ent_size;
  logic [POINTERS_PER_FILE*BW-1:0] ent_ptrs;
  assign ent_name = ent[MemW-1 -: NameW];
  assign ent_size = ent[POINTERS_PER_FILE*BW +: CountW];
  assign ent_ptrs = ent[POINTERS_PER_FILE*BW-1:0];

  iba_bitmap #(.BLOCK_COUNT(BLOCK_COUNT)) u_bitmap (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (bptr[BW-1:0]),
    .rd_taken (bm_taken),
    .wr_en    (bm_we),
    .wr_addr  (bm_waddr),
    .wr_taken (bm_wval)
  );

  // Inode memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_addr = (state == S_SRD) ? idx[IW-1:0] : hit_slot;

  // Create commits a fresh entry and marks its blocks taken; delete frees the file's blocks and clears its entry
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = free_slot;
    mem_wdata = {cmd.name_key, cmd.block_count, found};
    bm_we = 1'b0;
    bm_waddr = found[pj[PW-1:0]*BW +: BW];
    bm_wval = 1'b1;
    if (state == S_WRITE) begin
      mem_we = (pj == '0);
      bm_we = (pj < PW'(0) + (PW+1)'(cmd.block_count));
    end else if (state == S_FREE) begin
      bm_we = (pj < (PW+1)'(ent_size)) && (pj < (PW+1)'(POINTERS_PER_FILE));
      bm_waddr = ent_ptrs[pj[PW-1:0]*BW +: BW];
      bm_wval = 1'b0;
    end else if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = hit_slot;
      mem_wdata = '0;
    end
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.payload = result;

  // Sequence one command through search, scan and update
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cmd <= req.payload;
            idx <= '0;
            hit <= 1'b0;
            has_free <= 1'b0;
            hit_slot <= '0;
            free_slot <= '0;
            result <= '0;
            state <= (req.payload.operation == 2'd3) ? S_OUT : S_SRD;
          end
        end
        // Read each inode in turn
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (used[idx[IW-1:0]] && rd_data[MemW-1 -: NameW] == cmd.name_key
              && !hit) begin
            hit <= 1'b1;
            hit_slot <= idx[IW-1:0];
            ent <= rd_data;
          end
          if (!used[idx[IW-1:0]] && !has_free) begin
            has_free <= 1'b1;
            free_slot <= idx[IW-1:0];
          end
          if (idx == (IW+1)'(INODE_COUNT - 1)) begin
            state <= S_DISP;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        S_DISP: begin
          bptr <= '0;
          got <= '0;
          pj <= '0;
          found <= '0;
          if (cmd.operation == OP_CREATE) begin
            if (hit) begin
              result.status <= ST_EXISTS;
              state <= S_OUT;
            end else if (!has_free) begin
              result.status <= ST_NO_INODE;
              state <= S_OUT;
            end else if (cmd.block_count == '0 ||
                         cmd.block_count > CountW'(POINTERS_PER_FILE)) begin
              result.status <= ST_NO_BLOCKS;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end else if (!hit) begin
            result.status <= ST_NOT_FOUND;
            state <= S_OUT;
          end else if (cmd.operation == OP_DELETE) begin
            result.inode_slot <= SlotW'(hit_slot);
            state <= S_FREE;
          end else begin
            result.inode_slot <= SlotW'(hit_slot);
            if (CountW'(cmd.block_index) >= ent_size ||
                32'(cmd.block_index) >= POINTERS_PER_FILE) begin
              result.status <= ST_BAD_INDEX;
            end else begin
              result.block_address <=
                AddrW'(ent_ptrs[PW'(cmd.block_index)*BW +: BW]);
            end
            state <= S_OUT;
          end
        end
        // Read one bitmap bit; result comes the next cycle
        S_SCAN: begin
          state <= S_SCHECK;
        end
        S_SCHECK: begin
          if (!bm_taken) begin
            found[got[PW-1:0]*BW +: BW] <= bptr[BW-1:0];
            got <= got + 1'b1;
          end
          if (!bm_taken && (got + 1'b1) == PCW'(cmd.block_count)) begin
            state <= S_WRITE;
          end else if (bptr == (BW+1)'(BLOCK_COUNT - 1)) begin
            result.status <= ST_NO_BLOCKS;
            state <= S_OUT;
          end else begin
            bptr <= bptr + 1'b1;
            state <= S_SCAN;
          end
        end
        // Mark found blocks taken, one a cycle
        S_WRITE: begin
          if (pj == '0) begin
            used[free_slot] <= 1'b1;
            result.inode_slot <= SlotW'(free_slot);
            result.block_address <= AddrW'(found[BW-1:0]);
          end
          if (pj + 1'b1 >= (PW+1)'(cmd.block_count)) begin
            state <= S_OUT;
          end else begin
            pj <= pj + 1'b1;
          end
        end
        S_ALLOC: begin
          state <= S_OUT;
        end
        // Release the file's own pointers
        S_FREE: begin
          if (pj + 1'b1 >= (PW+1)'(POINTERS_PER_FILE)) begin
            state <= S_CLEAR;
          end else begin
            pj <= pj + 1'b1;
          end
        end
        S_CLEAR: begin
          used[hit_slot] <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The result register is never overwritten while it waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> out_valid && $stable(result))
    else $error("result overwritten while stalled");
  // No command is taken while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !req.ready)
    else $error("request taken with result pending");
  // Block address is zero on every failure
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status != ST_OK) |-> result.block_address == '0)
    else $error("address set on failure");
`endif
endmodule
`default_nettype wire
